[sv/fhl_pkg.sv]
package fhl_pkg;

    // Number of heat slots and LEDs in the strip (8 to 64).
    localparam int NUM_LEDS = 32;
    localparam int CNT_W    = $clog2(NUM_LEDS);

    localparam int HEAT_W  = 8;
    localparam int RANGE_W = 9;
    localparam int LFSR_W  = 32;

    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 32'h8020_0003;
    localparam logic [LFSR_W-1:0] LFSR_RESET = 32'd1;

    localparam logic [7:0] COOLING_RESET = 8'd10;
    localparam logic [7:0] SPARK_RESET   = 8'd50;
    localparam int         COOL_MUL      = 10;

    // cooling_rate*10/NUM_LEDS as a multiply by a rounded-up reciprocal. The error stays
    // below one step of the quotient for every 8-bit rate and every strip length.
    localparam int COOL_SHIFT  = 20;
    localparam int COOL_RECIP  = COOL_MUL * (((1 << COOL_SHIFT) + NUM_LEDS - 1) / NUM_LEDS);
    localparam int COOL_PROD_W = COOL_SHIFT + RANGE_W;

    localparam logic [RANGE_W-1:0] SPARK_RANGE = 9'd255;
    localparam logic [RANGE_W-1:0] SPARK_CELLS = 9'd7;
    localparam logic [RANGE_W-1:0] SPARK_SPAN  = 9'd95;
    localparam logic [RANGE_W-1:0] LED_RANGE   = RANGE_W'(NUM_LEDS);
    localparam logic [HEAT_W-1:0]  SPARK_MIN   = 8'd160;

    typedef enum logic [1:0] {
        CFG_SEED    = 2'd0,
        CFG_COOLING = 2'd1,
        CFG_SPARK   = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_COOL,
        S_SPARK,
        S_ROT,
        S_SEL,
        S_ADD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               step;
        logic               load;
        logic [LFSR_W-1:0]  seed;
        logic [RANGE_W-1:0] span;
    } t_rng_req;

    typedef struct packed {
        logic              shift;
        logic              add;
        logic [HEAT_W-1:0] amount;
    } t_slot_ctl;

endpackage

[sv/fhl_slot.sv]
module fhl_slot import fhl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_slot_ctl         i_ctl,
    input  logic [HEAT_W-1:0] i_heat,
    output logic [HEAT_W-1:0] o_heat
);

    logic [HEAT_W-1:0] r_heat;
    logic [HEAT_W:0]   w_sum;

    assign w_sum  = {1'b0, r_heat} + {1'b0, i_ctl.amount};
    assign o_heat = r_heat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat <= '0;
        end else if (i_ctl.shift) begin
            r_heat <= i_heat;
        end else if (i_ctl.add) begin
            // A spark saturates at full heat.
            r_heat <= w_sum[HEAT_W] ? {HEAT_W{1'b1}} : w_sum[HEAT_W-1:0];
        end
    end

endmodule

[sv/fhl_rng.sv]
module fhl_rng import fhl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_rng_req           i_req,
    output logic [RANGE_W-1:0] o_draw
);

    logic [LFSR_W-1:0]     r_lfsr;
    logic [LFSR_W-1:0]     n_lfsr;
    logic [LFSR_W-1:0]     w_stepped;
    logic [15+RANGE_W:0]   w_prod;

    assign w_stepped = {1'b0, r_lfsr[LFSR_W-1:1]} ^ (r_lfsr[0] ? LFSR_TAPS : '0);

    // The draw scales the upper half of the stepped word into the span.
    assign w_prod = (16+RANGE_W)'(w_stepped[LFSR_W-1:16]) * (16+RANGE_W)'(i_req.span);
    assign o_draw = w_prod[15+RANGE_W:16];

    always_comb begin
        n_lfsr = r_lfsr;
        if (i_req.load) begin
            n_lfsr = (i_req.seed != '0) ? i_req.seed : LFSR_RESET;
        end else if (i_req.step) begin
            n_lfsr = w_stepped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= LFSR_RESET;
        end else begin
            r_lfsr <= n_lfsr;
        end
    end

endmodule

[sv/fire_heat_led_frame.sv]
// A frame forms the cooling bound, makes the cooling and drift pass around the ring of
// heat slots, runs the spark test (followed on a spark by the draws of the rotation, the
// spark cell and the spark amount), and then emits the colors, one word per cycle while
// the output is taken. The idle state takes the tick. The ring moves one slot past its
// head per cycle in the cooling pass, and in the emit pass only when a word is emitted.
// A new tick is taken only when the previous frame has been handed to the output
// register.
module fire_heat_led_frame import fhl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_tick_valid,
    output logic        o_tick_ready,
    input  logic        i_tick,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_pixel_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_last_pixel
);

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]       r_cnt;
    logic [RANGE_W-1:0]     r_div;
    logic [COOL_PROD_W-1:0] w_cool_prod;
    logic [RANGE_W-1:0]     w_bound;
    logic [7:0]             r_cooling;
    logic [7:0]             r_spark;
    logic [5:0]             r_rotation;
    logic [2:0]             r_sel;
    logic [HEAT_W-1:0]      r_c1;
    logic [HEAT_W-1:0]      r_c2;

    logic               r_out_valid;
    logic [5:0]         r_pixel;
    logic [7:0]         r_red;
    logic [7:0]         r_green;
    logic [7:0]         r_blue;
    logic               r_last;

    t_rng_req           c_rng;
    logic [RANGE_W-1:0] w_draw;
    logic               c_shift;
    logic               c_add;
    logic [HEAT_W-1:0]  c_amount;
    logic               c_emit;
    logic               w_last_cnt;
    logic               w_accept;

    logic [HEAT_W-1:0]  w_heat [NUM_LEDS];
    t_slot_ctl          w_ctl  [NUM_LEDS];
    logic [HEAT_W-1:0]  w_head;
    logic [HEAT_W-1:0]  w_cooled;
    logic [9:0]         w_sum;
    logic [19:0]        w_prod3;
    logic [HEAT_W-1:0]  w_drift;
    logic [HEAT_W-1:0]  w_tail;

    logic [15:0]        w_x;
    logic [16:0]        w_x1;
    logic [7:0]         w_t;
    logic [7:0]         w_ramp;
    logic [6:0]         w_pix_sum;
    logic [6:0]         w_pix;

    assign w_head      = w_heat[0];
    assign w_last_cnt  = (r_cnt == CNT_W'(NUM_LEDS - 1));
    assign w_accept    = i_tick_valid && o_tick_ready;
    assign c_emit      = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign w_cool_prod = COOL_PROD_W'(r_cooling) * COOL_PROD_W'(COOL_RECIP);
    assign w_bound     = r_div + RANGE_W'(2);

    fhl_rng u_rng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (c_rng),
        .o_draw  (w_draw)
    );

    // The ring shifts toward slot 0; the head leaves slot 0 and the new value enters
    // at the top slot, so a full pass leaves the ring in order.
    for (genvar k = 0; k < NUM_LEDS; k++) begin : g_slot
        assign w_ctl[k] = '{shift: c_shift, add: c_add && (int'(r_sel) == k),
                            amount: c_amount};
        if (k == NUM_LEDS - 1) begin : g_top
            fhl_slot u_slot (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[k]),
                .i_heat  (w_tail),
                .o_heat  (w_heat[k])
            );
        end else begin : g_mid
            fhl_slot u_slot (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[k]),
                .i_heat  (w_heat[k+1]),
                .o_heat  (w_heat[k])
            );
        end
    end

    // Cooling of the head slot, then drift from the two previously cooled slots.
    assign w_cooled = (w_draw > {1'b0, w_head}) ? '0 : (w_head - w_draw[HEAT_W-1:0]);
    assign w_sum    = {2'b00, r_c1} + {1'b0, r_c2, 1'b0};
    // Multiply by 683/2048 gives the exact quotient by three for sums up to 765.
    assign w_prod3  = 20'(w_sum) * 20'd683;
    assign w_drift  = w_prod3[18:11];
    assign w_tail   = (r_state == S_COOL)
                    ? ((r_cnt < CNT_W'(2)) ? w_cooled : w_drift)
                    : w_head;

    // Color: t = round(h*191/255), divide by 255 done with the add-and-shift identity.
    assign w_x    = 16'(w_head) * 16'd191 + 16'd127;
    assign w_x1   = {1'b0, w_x} + 17'd1 + 17'(w_x[15:8]);
    assign w_t    = w_x1[15:8];
    assign w_ramp = {w_t[5:0], 2'b00};

    assign w_pix_sum = 7'(r_cnt) + 7'(r_rotation);
    assign w_pix     = (w_pix_sum >= 7'(NUM_LEDS)) ? (w_pix_sum - 7'(NUM_LEDS)) : w_pix_sum;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_tick) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: n_state = S_COOL;
            S_COOL: begin
                if (w_last_cnt) begin
                    n_state = S_SPARK;
                end
            end
            S_SPARK: begin
                n_state = (w_draw < {1'b0, r_spark}) ? S_ROT : S_EMIT;
            end
            S_ROT: n_state = S_SEL;
            S_SEL: n_state = S_ADD;
            S_ADD: n_state = S_EMIT;
            S_EMIT: begin
                if (c_emit && w_last_cnt) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        c_rng.step = 1'b0;
        c_rng.load = i_cfg_we && (i_cfg_index == CFG_SEED);
        c_rng.seed = i_cfg_data;
        c_rng.span = w_bound;
        c_shift    = 1'b0;
        c_add      = 1'b0;
        c_amount   = SPARK_MIN + w_draw[HEAT_W-1:0];
        o_tick_ready = 1'b0;
        case (r_state)
            S_IDLE: o_tick_ready = 1'b1;
            S_COOL: begin
                c_rng.step = 1'b1;
                c_shift    = 1'b1;
            end
            S_SPARK: begin
                c_rng.step = 1'b1;
                c_rng.span = SPARK_RANGE;
            end
            S_ROT: begin
                c_rng.step = 1'b1;
                c_rng.span = LED_RANGE;
            end
            S_SEL: begin
                c_rng.step = 1'b1;
                c_rng.span = SPARK_CELLS;
            end
            S_ADD: begin
                c_rng.step = 1'b1;
                c_rng.span = SPARK_SPAN;
                c_add      = 1'b1;
            end
            S_EMIT: c_shift = c_emit;
            default: c_shift = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_rotation <= '0;
            r_cooling  <= COOLING_RESET;
            r_spark    <= SPARK_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COOLING: r_cooling <= i_cfg_data[7:0];
                    CFG_SPARK:   r_spark   <= i_cfg_data[7:0];
                    default:     r_spark   <= r_spark;
                endcase
            end
            if (r_state == S_IDLE) begin
                r_cnt <= '0;
            end else if ((r_state == S_COOL) || c_emit) begin
                r_cnt <= w_last_cnt ? '0 : (r_cnt + CNT_W'(1));
            end
            if (r_state == S_ROT) begin
                r_rotation <= w_draw[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV) begin
            r_div <= w_cool_prod[COOL_PROD_W-1:COOL_SHIFT];
        end
        if (r_state == S_COOL) begin
            r_c1 <= w_cooled;
            r_c2 <= r_c1;
        end
        if (r_state == S_SEL) begin
            r_sel <= w_draw[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_emit) begin
            r_pixel <= w_pix[5:0];
            r_last  <= w_last_cnt;
            if (w_t > 8'h80) begin
                r_red   <= 8'hFF;
                r_green <= 8'hFF;
                r_blue  <= w_ramp;
            end else if (w_t > 8'h40) begin
                r_red   <= 8'hFF;
                r_green <= w_ramp;
                r_blue  <= 8'h00;
            end else begin
                r_red   <= w_ramp;
                r_green <= 8'h00;
                r_blue  <= 8'h00;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_pixel;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_last_pixel  = r_last;

`ifndef NO_ASSERTIONS
    a_spark_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPARK) |->
            ($past(r_state) == S_COOL) && ($past(r_cnt) == CNT_W'(NUM_LEDS - 1)))
        else $error("spark test reached before the cooling pass completed");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && r_out_valid && !i_out_ready) |=> $stable(r_cnt))
        else $error("ring advanced while the output word was stalled");

    a_rotation_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL) |-> (7'(r_rotation) < 7'(NUM_LEDS)))
        else $error("rotation outside the strip");
`endif

endmodule

[tb/sv/fire_heat_led_frame_checker.sv]
module fire_heat_led_frame_checker import fhl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_tick_valid,
    input  logic        i_tick_ready,
    input  logic        i_tick,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [5:0]  i_pixel_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_last_pixel,
    output int          o_failures,
    output int          o_pending,
    output int          o_frames,
    output int          o_sparks,
    output int          o_saturations,
    output int          o_words
);

    localparam int HEAT_SCALE = 191;
    localparam int HEAT_FULL  = 255;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic [5:0] pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_led_word;

    t_led_word         expected_leds[$];
    logic [7:0]        cooling_rate;
    logic [7:0]        spark_chance;
    logic [HEAT_W-1:0] heat_cells [NUM_LEDS];
    logic [5:0]        rotation;
    logic [LFSR_W-1:0] lfsr_word;
    int                failure_count;
    int                frame_count;
    int                spark_count;
    int                saturation_count;
    int                word_count;

    assign o_failures    = failure_count;
    assign o_frames      = frame_count;
    assign o_sparks      = spark_count;
    assign o_saturations = saturation_count;
    assign o_words       = word_count;

    task automatic report(input string what);
        begin
            if (failure_count < MAX_PRINTS) begin
                $display("[%0t] led word mismatch: %s", $time, what);
            end
            failure_count++;
        end
    endtask

    // One step of the Galois generator, then a scaled draw over [0, span).
    task automatic draw_random(input logic [RANGE_W-1:0] span,
                               output logic [RANGE_W-1:0] value);
        logic lsb;
        begin
            lsb = lfsr_word[0];
            lfsr_word = lfsr_word >> 1;
            if (lsb) begin
                lfsr_word = lfsr_word ^ LFSR_TAPS;
            end
            value = RANGE_W'((32'(lfsr_word[31:16]) * 32'(span)) >> 16);
        end
    endtask

    task automatic predict_frame();
        logic [RANGE_W-1:0] bound;
        logic [RANGE_W-1:0] value;
        logic [RANGE_W-1:0] spark_cell;
        int                 sum;
        int                 t;
        logic [7:0]         ramp;
        t_led_word          w;
        begin
            bound = RANGE_W'(int'(cooling_rate) * COOL_MUL / NUM_LEDS + 2);
            for (int k = 0; k < NUM_LEDS; k++) begin
                draw_random(bound, value);
                heat_cells[k] = (value > heat_cells[k]) ? '0 : heat_cells[k] - value[7:0];
            end
            for (int k = NUM_LEDS - 1; k >= 2; k--) begin
                heat_cells[k] = HEAT_W'((int'(heat_cells[k-1]) + 2 * int'(heat_cells[k-2])) / 3);
            end
            draw_random(SPARK_RANGE, value);
            if (value < spark_chance) begin
                spark_count++;
                draw_random(LED_RANGE, value);
                rotation = value[5:0];
                draw_random(SPARK_CELLS, spark_cell);
                draw_random(SPARK_SPAN, value);
                sum = int'(heat_cells[spark_cell]) + int'(SPARK_MIN) + int'(value);
                if (sum > HEAT_FULL) begin
                    saturation_count++;
                    sum = HEAT_FULL;
                end
                heat_cells[spark_cell] = HEAT_W'(sum);
            end
            for (int k = 0; k < NUM_LEDS; k++) begin
                t = (int'(heat_cells[k]) * HEAT_SCALE + 127) / HEAT_FULL;
                ramp = 8'((t & 'h3F) << 2);
                w.pixel = 6'((k + int'(rotation)) % NUM_LEDS);
                if (t > 'h80) begin
                    w.red = 8'hFF;
                    w.green = 8'hFF;
                    w.blue = ramp;
                end else if (t > 'h40) begin
                    w.red = 8'hFF;
                    w.green = ramp;
                    w.blue = 8'h00;
                end else begin
                    w.red = ramp;
                    w.green = 8'h00;
                    w.blue = 8'h00;
                end
                w.last = (k == NUM_LEDS - 1);
                expected_leds.push_back(w);
            end
            frame_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_led_word w;
        if (!i_rst_n) begin
            cooling_rate = COOLING_RESET;
            spark_chance = SPARK_RESET;
            rotation = '0;
            lfsr_word = LFSR_RESET;
            for (int k = 0; k < NUM_LEDS; k++) begin
                heat_cells[k] = '0;
            end
            expected_leds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SEED: begin
                        // A zero seed would lock the generator, so it restarts from one.
                        lfsr_word = (i_cfg_data != '0) ? i_cfg_data : LFSR_RESET;
                    end
                    CFG_COOLING: cooling_rate = i_cfg_data[7:0];
                    CFG_SPARK:   spark_chance = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_tick_valid && i_tick_ready && i_tick) begin
                predict_frame();
            end
            if (i_out_valid && i_out_ready) begin
                word_count++;
                if (expected_leds.size() == 0) begin
                    report($sformatf("word at pixel %0d with nothing expected", i_pixel_index));
                end else begin
                    w = expected_leds.pop_front();
                    if (i_pixel_index !== w.pixel) begin
                        report($sformatf("pixel_index got %0d expected %0d",
                                         i_pixel_index, w.pixel));
                    end
                    if (i_red !== w.red) begin
                        report($sformatf("red got %0d expected %0d", i_red, w.red));
                    end
                    if (i_green !== w.green) begin
                        report($sformatf("green got %0d expected %0d", i_green, w.green));
                    end
                    if (i_blue !== w.blue) begin
                        report($sformatf("blue got %0d expected %0d", i_blue, w.blue));
                    end
                    if (i_last_pixel !== w.last) begin
                        report($sformatf("last_pixel got %b expected %b", i_last_pixel, w.last));
                    end
                end
            end
        end
        o_pending <= expected_leds.size();
    end

endmodule

[tb/sv/fire_heat_led_frame_tb.sv]
module fire_heat_led_frame_tb;
    import fhl_pkg::*;

    localparam int          ITEMS          = 450;
    localparam int          STEADY_RUN     = 60;
    localparam int          DIRECTED_ITEMS = 20;
    localparam int          SETTLE         = 2 * NUM_LEDS + 24;
    localparam logic [1:0]  CFG_UNUSED     = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_SEED;
    logic [31:0] i_cfg_data = '0;
    logic        i_tick_valid = 1'b0;
    logic        i_tick = 1'b1;
    logic        i_out_ready = 1'b0;
    logic        o_tick_ready;
    logic        o_out_valid;
    logic [5:0]  o_pixel_index;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        o_last_pixel;

    int failures;
    int pending;
    int frames;
    int sparks;
    int saturations;
    int words;
    bit steady = 1'b0;

    fire_heat_led_frame uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_tick_valid  (i_tick_valid),
        .o_tick_ready  (o_tick_ready),
        .i_tick        (i_tick),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_index (o_pixel_index),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_last_pixel  (o_last_pixel)
    );

    fire_heat_led_frame_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_tick_valid  (i_tick_valid),
        .i_tick_ready  (o_tick_ready),
        .i_tick        (i_tick),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_pixel_index (o_pixel_index),
        .i_red         (o_red),
        .i_green       (o_green),
        .i_blue        (o_blue),
        .i_last_pixel  (o_last_pixel),
        .o_failures    (failures),
        .o_pending     (pending),
        .o_frames      (frames),
        .o_sparks      (sparks),
        .o_saturations (saturations),
        .o_words       (words)
    );

    initial begin
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    initial begin
        #(24_000_000);
        $display("FAILURE");
        $finish;
    end

    // The receiver stalls in bursts until the final stretch of the run.
    initial begin
        forever begin
            @(posedge i_clk);
            if (!steady && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // Valid stays high between back-to-back ticks; it only drops for a gap.
    task automatic send_tick(input logic value);
        begin
            if (!steady && $urandom_range(0, 4) == 0) begin
                i_tick_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            i_tick_valid <= 1'b1;
            i_tick <= value;
            @(posedge i_clk);
            while (!o_tick_ready) @(posedge i_clk);
        end
    endtask

    // The pending count is registered, so it is first read in the cycle after the last accept.
    task automatic drain_frames();
        begin
            i_tick_valid <= 1'b0;
            @(posedge i_clk);
            while (pending != 0) @(posedge i_clk);
            repeat (SETTLE) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [1:0] index, input logic [31:0] data);
        begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= index;
            i_cfg_data <= data;
            @(posedge i_clk);
        end
    endtask

    task automatic cfg_done();
        begin
            i_cfg_we <= 1'b0;
        end
    endtask

    task automatic pick_settings();
        logic [31:0] seed;
        logic [7:0]  cooling;
        logic [7:0]  chance;
        begin
            case ($urandom_range(0, 4))
                0:       seed = '0;
                1:       seed = '1;
                default: seed = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       cooling = 8'd0;
                1:       cooling = 8'd255;
                default: cooling = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
                0:       chance = 8'd0;
                1:       chance = 8'd255;
                default: chance = 8'($urandom_range(0, 255));
            endcase
            drain_frames();
            if ($urandom_range(0, 3) != 0) cfg_write(CFG_SEED, seed);
            if ($urandom_range(0, 3) != 0) cfg_write(CFG_COOLING, {$urandom} & ~32'hFF | cooling);
            if ($urandom_range(0, 3) != 0) cfg_write(CFG_SPARK, {$urandom} & ~32'hFF | chance);
            if ($urandom_range(0, 5) == 0) cfg_write(CFG_UNUSED, $urandom);
            cfg_done();
        end
    endtask

    initial begin : stimulus
        int sent;
        int burst;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, with an empty tick in between.
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        // A zero seed, a zero cooling rate and a spark every frame drive the base cells to saturation.
        drain_frames();
        cfg_write(CFG_SEED, 32'h0000_0000);
        cfg_write(CFG_COOLING, 32'h0000_0000);
        cfg_write(CFG_SPARK, 32'h0000_00FF);
        cfg_done();
        repeat (8) send_tick(1'b1);

        // Strongest cooling with no sparks; the unused index must change nothing.
        drain_frames();
        cfg_write(CFG_SEED, 32'hFFFF_FFFF);
        cfg_write(CFG_COOLING, 32'hFFFF_FFFF);
        cfg_write(CFG_SPARK, 32'hFFFF_FF00);
        cfg_write(CFG_UNUSED, 32'h5A5A_A5A5);
        cfg_done();
        repeat (4) send_tick(1'b1);
        send_tick(1'b0);

        drain_frames();
        cfg_write(CFG_SEED, $urandom);
        cfg_write(CFG_SPARK, 32'h0000_00FF);
        cfg_done();
        repeat (4) send_tick(1'b1);

        sent = DIRECTED_ITEMS;
        while (sent < ITEMS - STEADY_RUN) begin
            pick_settings();
            burst = $urandom_range(20, 70);
            repeat (burst) begin
                if (sent < ITEMS - STEADY_RUN) begin
                    if ($urandom_range(0, 49) == 0) drain_frames();
                    if ($urandom_range(0, 9) == 0) begin
                        send_tick(1'b0);
                    end else begin
                        send_tick(1'b1);
                    end
                    sent++;
                end
            end
        end

        pick_settings();
        steady = 1'b1;
        repeat (STEADY_RUN) send_tick(1'b1);
        drain_frames();

        $display("Ran %0d frames, %0d with a spark and %0d with a saturated spark;",
                 frames, sparks, saturations);
        $display("%0d words checked across zero and full seeds, cooling and spark extremes,",
                 words);
        $display("and empty ticks.");
        if (failures == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
